@@ rtl/core/rsnh_pkg.sv @@
// ----------------------------------------------------------------------------
// rsnh_pkg
// shared types, command codes and helpers of the ray-sphere nearest-hit block
// ----------------------------------------------------------------------------
`default_nettype none

package rsnh_pkg;

    localparam int SPHERE_W = 159;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_DIFF,
        OP_ACC,
        OP_TC,
        OP_DIST,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_UPDATE,
        OP_POINT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic early_skip;
        logic late_skip;
    } dp_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIFF,
        ST_ACC,
        ST_TC,
        ST_DIST,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_UPDATE,
        ST_POINT,
        ST_OUT
    } ctrl_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/rsnh_ram.sv @@
// ----------------------------------------------------------------------------
// rsnh_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rsnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/rsnh_datapath.sv @@
// ----------------------------------------------------------------------------
// rsnh_datapath
// sphere table, shared multiplier, sqrt iteration and nearest-hit registers
// ----------------------------------------------------------------------------
`default_nettype none

module rsnh_datapath #(
    parameter int MAX_SPHERES = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rsnh_pkg::dp_cmd_t     cmd,
    input  wire logic [(MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1)-1:0] raddr,
    output rsnh_pkg::dp_stat_t         stat,
    input  wire logic [5:0]            slot,
    input  wire logic signed [31:0]    pos_x,
    input  wire logic signed [31:0]    pos_y,
    input  wire logic signed [31:0]    pos_z,
    input  wire logic signed [17:0]    dir_x,
    input  wire logic signed [17:0]    dir_y,
    input  wire logic signed [17:0]    dir_z,
    input  wire logic [30:0]           radius,
    input  wire logic [31:0]           color_rgba,
    output logic                       hit,
    output logic signed [31:0]         hit_t,
    output logic [31:0]                hit_color,
    output logic signed [31:0]         center_x,
    output logic signed [31:0]         center_y,
    output logic signed [31:0]         center_z,
    output logic signed [31:0]         point_x,
    output logic signed [31:0]         point_y,
    output logic signed [31:0]         point_z
);
    import rsnh_pkg::*;

    localparam int AW = MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1;

    logic                  we;
    logic [SPHERE_W-1:0]   rdata;

    logic signed [31:0] o_reg [3];
    logic signed [17:0] dir_reg [3];
    logic signed [31:0] c_reg [3];
    logic [30:0]        rad_reg;
    logic [31:0]        col_reg;
    logic signed [31:0] diff_reg [3];
    logic [63:0]        dist2_reg;
    logic signed [63:0] dot_reg;
    logic [63:0]        r2_reg;
    logic signed [31:0] tc_reg;
    logic               inside_reg;
    logic signed [31:0] d_reg [3];
    logic [63:0]        d2_reg;
    logic [63:0]        sq_v_reg;
    logic [63:0]        sq_res_reg;
    logic [63:0]        sq_bit_reg;
    logic               found_reg;
    logic signed [31:0] best_t_reg;
    logic signed [31:0] best_c_reg [3];
    logic [31:0]        best_col_reg;
    logic signed [31:0] point_reg [3];

    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic [1:0]         k;
    logic signed [31:0] tc_calc;
    logic               inside_calc;
    logic [63:0]        sq_trial;
    logic signed [63:0] off_s;
    logic signed [31:0] t_calc;

    assign we = (cmd.op == OP_LOAD) && (32'(slot) < MAX_SPHERES);

    rsnh_ram #(
        .WIDTH (SPHERE_W),
        .DEPTH (MAX_SPHERES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(slot)),
        .wdata ({pos_x, pos_y, pos_z, radius, color_rgba}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign k = (cmd.step < 5'd3) ? cmd.step[1:0] :
               (cmd.step < 5'd6) ? 2'(cmd.step - 5'd3) : 2'd0;

    always_comb
    begin
        mul_a = diff_reg[k];
        mul_b = diff_reg[k];
        case (cmd.op)
            OP_ACC:
            begin
                if (cmd.step == 5'd6)
                begin
                    mul_a = signed'({1'b0, rad_reg});
                    mul_b = signed'({1'b0, rad_reg});
                end
                else if (cmd.step >= 5'd3)
                    mul_b = 32'(dir_reg[k]);
            end
            OP_DIST:
            begin
                if (cmd.step < 5'd3)
                begin
                    mul_a = tc_reg;
                    mul_b = 32'(dir_reg[k]);
                end
                else
                begin
                    mul_a = d_reg[k];
                    mul_b = d_reg[k];
                end
            end
            OP_POINT:
            begin
                mul_a = best_t_reg;
                mul_b = 32'(dir_reg[k]);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign tc_calc     = sat32(dot_reg >>> 16);
    assign inside_calc = dist2_reg < r2_reg;
    assign sq_trial    = sq_res_reg + sq_bit_reg;
    assign off_s       = signed'({32'd0, sq_res_reg[31:0]});
    assign t_calc      = inside_reg ? sat32(64'(tc_reg) + off_s) : sat32(64'(tc_reg) - off_s);

    assign stat.early_skip = !inside_calc && tc_calc[31];
    assign stat.late_skip  = !inside_reg && (r2_reg < d2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.op == OP_START)
            found_reg <= 1'b0;
        else if (cmd.op == OP_UPDATE)
            found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                o_reg[0]   <= pos_x;
                o_reg[1]   <= pos_y;
                o_reg[2]   <= pos_z;
                dir_reg[0] <= dir_x;
                dir_reg[1] <= dir_y;
                dir_reg[2] <= dir_z;
            end
            OP_DIFF:
            begin
                c_reg[0]    <= rdata[158:127];
                c_reg[1]    <= rdata[126:95];
                c_reg[2]    <= rdata[94:63];
                rad_reg     <= rdata[62:32];
                col_reg     <= rdata[31:0];
                diff_reg[0] <= sat32(64'(signed'(rdata[158:127])) - 64'(o_reg[0]));
                diff_reg[1] <= sat32(64'(signed'(rdata[126:95])) - 64'(o_reg[1]));
                diff_reg[2] <= sat32(64'(signed'(rdata[94:63])) - 64'(o_reg[2]));
                dist2_reg   <= '0;
                dot_reg     <= '0;
                d2_reg      <= '0;
            end
            OP_ACC:
            begin
                if (cmd.step < 5'd3)
                    dist2_reg <= dist2_reg + unsigned'(mul_p);
                else if (cmd.step < 5'd6)
                    dot_reg <= dot_reg + mul_p;
                else
                    r2_reg <= unsigned'(mul_p);
            end
            OP_TC:
            begin
                tc_reg     <= tc_calc;
                inside_reg <= inside_calc;
            end
            OP_DIST:
            begin
                if (cmd.step < 5'd3)
                    d_reg[k] <= sat32((mul_p >>> 16) - 64'(diff_reg[k]));
                else
                    d2_reg <= d2_reg + unsigned'(mul_p);
            end
            OP_SQRT_INIT:
            begin
                sq_v_reg   <= (r2_reg > d2_reg) ? r2_reg - d2_reg : 64'd0;
                sq_res_reg <= '0;
                sq_bit_reg <= 64'd1 << 62;
            end
            OP_SQRT:
            begin
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_reg   <= sq_v_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_UPDATE:
            begin
                if (!found_reg || t_calc < best_t_reg)
                begin
                    best_t_reg    <= t_calc;
                    best_c_reg[0] <= c_reg[0];
                    best_c_reg[1] <= c_reg[1];
                    best_c_reg[2] <= c_reg[2];
                    best_col_reg  <= col_reg;
                end
            end
            OP_POINT:
                point_reg[k] <= sat32(64'(o_reg[k]) + (mul_p >>> 16));
            default: ;
        endcase
    end

    assign hit       = found_reg;
    assign hit_t     = found_reg ? best_t_reg : Q_MAX;
    assign hit_color = found_reg ? best_col_reg : 32'd0;
    assign center_x  = found_reg ? best_c_reg[0] : 32'sd0;
    assign center_y  = found_reg ? best_c_reg[1] : 32'sd0;
    assign center_z  = found_reg ? best_c_reg[2] : 32'sd0;
    assign point_x   = found_reg ? point_reg[0] : 32'sd0;
    assign point_y   = found_reg ? point_reg[1] : 32'sd0;
    assign point_z   = found_reg ? point_reg[2] : 32'sd0;

endmodule

`default_nettype wire

@@ rtl/core/rsnh_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsnh_ctrl
// sequencer: walks the spheres and steps the datapath through each test
// ----------------------------------------------------------------------------
`default_nettype none

module rsnh_ctrl #(
    parameter int MAX_SPHERES = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [6:0]           cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 req_type,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rsnh_pkg::dp_cmd_t         cmd,
    output logic [(MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1)-1:0] raddr,
    input  wire rsnh_pkg::dp_stat_t   stat
);
    import rsnh_pkg::*;

    localparam int AW = MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1;
    localparam int CW = $clog2(MAX_SPHERES + 1);

    ctrl_state_t state_reg, state_next;
    logic [6:0]    count_reg;
    logic [CW-1:0] n_reg, n_next, n_cur;
    logic [CW-1:0] idx_reg, idx_next, idx_inc;
    logic [4:0]    step_reg, step_next;

    assign n_cur   = (32'(count_reg) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(count_reg);
    assign idx_inc = idx_reg + 1'b1;
    assign raddr   = AW'(idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && !req_type)
                    cmd.op = OP_LOAD;
                else if (in_valid)
                begin
                    cmd.op   = OP_START;
                    n_next   = n_cur;
                    idx_next = '0;
                    step_next = '0;
                    state_next = (n_cur == '0) ? ST_POINT : ST_FETCH;
                end
            end
            ST_FETCH:
                state_next = ST_DIFF;
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                step_next  = '0;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op    = OP_ACC;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd6)
                    state_next = ST_TC;
            end
            ST_TC:
            begin
                cmd.op    = OP_TC;
                step_next = '0;
                if (stat.early_skip)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == n_reg) ? ST_POINT : ST_FETCH;
                end
                else
                    state_next = ST_DIST;
            end
            ST_DIST:
            begin
                cmd.op    = OP_DIST;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd5)
                    state_next = ST_SQRT_INIT;
            end
            ST_SQRT_INIT:
            begin
                cmd.op    = OP_SQRT_INIT;
                step_next = '0;
                if (stat.late_skip)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == n_reg) ? ST_POINT : ST_FETCH;
                end
                else
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op    = OP_SQRT;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.op     = OP_UPDATE;
                step_next  = '0;
                idx_next   = idx_inc;
                state_next = (idx_inc == n_reg) ? ST_POINT : ST_FETCH;
            end
            ST_POINT:
            begin
                cmd.op    = OP_POINT;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd2)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_stall) |=> (state_reg == ST_OUT))
        else $error("result dropped while stalled");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg <= n_reg))
        else $error("sphere index past count");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type) |=> (state_reg != ST_IDLE))
        else $error("cast transfer not started");

    a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !req_type) |=> (state_reg == ST_IDLE))
        else $error("load transfer left idle");

endmodule

`default_nettype wire

@@ rtl/core/ray_sphere_nearest_hit.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_nearest_hit
// nearest ray-sphere hit over a loaded sphere table, Q16.16 fixed point
//
// input channel (in_valid/in_stall): a load transfer writes one table slot
// and gives no result; a cast tests a ray against the first sphere_count
// slots (up to MAX_SPHERES) and gives one result on the output channel
// (out_valid/out_stall). in_stall stays high from a cast until its result
// is taken, and the next transfer is taken in the cycle after that. per cast,
// a sphere behind the ray is dropped early, a missed one after the distance
// test, and a hit one also runs the one-bit-per-cycle square root (one
// shared 32x32 multiplier); the hit point is then computed before out_valid
// rises. sphere_count is written through cfg_wr_en/cfg_wr_data; the user
// must write it only while idle, the block does not enforce it. reset
// clears sphere_count and the sequencer; table contents are undefined
// until loaded. a stalled result holds until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_nearest_hit #(
    parameter int MAX_SPHERES = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [6:0]         cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [5:0]         slot,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [17:0] dir_x,
    input  wire logic signed [17:0] dir_y,
    input  wire logic signed [17:0] dir_z,
    input  wire logic [30:0]        radius,
    input  wire logic [31:0]        color_rgba,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic signed [31:0]      hit_t,
    output logic [31:0]             hit_color,
    output logic signed [31:0]      center_x,
    output logic signed [31:0]      center_y,
    output logic signed [31:0]      center_z,
    output logic signed [31:0]      point_x,
    output logic signed [31:0]      point_y,
    output logic signed [31:0]      point_z
);
    import rsnh_pkg::*;

    localparam int AW = MAX_SPHERES > 1 ? $clog2(MAX_SPHERES) : 1;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [AW-1:0] raddr;

    rsnh_ctrl #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .raddr       (raddr),
        .stat        (stat)
    );

    rsnh_datapath #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .raddr      (raddr),
        .stat       (stat),
        .slot       (slot),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .radius     (radius),
        .color_rgba (color_rgba),
        .hit        (hit),
        .hit_t      (hit_t),
        .hit_color  (hit_color),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z)
    );

endmodule

`default_nettype wire
